### rtl/core/vector_distance_accumulator_assert.svh
// Assertion macros shared by the vector distance accumulator checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define VDA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vda assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define VDA_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vda assertion failed");

`endif

### rtl/core/vda_pkg.sv
// Shared types and constants of the vector distance accumulator.
// No dependencies.
package vda_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int SUM_W         = 64;
	localparam int MET_W         = 3;

	// metric register codes
	localparam logic [MET_W-1:0] MET_EUCLID    = 3'd0;
	localparam logic [MET_W-1:0] MET_MAXIMUM   = 3'd1;
	localparam logic [MET_W-1:0] MET_MANHATTAN = 3'd2;
	localparam logic [MET_W-1:0] MET_CANBERRA  = 3'd3;
	localparam logic [MET_W-1:0] MET_JACCARD   = 3'd4;
	localparam logic [MET_W-1:0] MET_OVERLAP   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CDIV,
		ST_ACC,
		ST_FIN,
		ST_SQRT,
		ST_JDIV,
		ST_EMIT
	} vda_state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic cdiv_start;
		logic jdiv_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic accumulate;
		logic emit;
	} vda_cmd_t;

	typedef struct packed {
		logic need_cdiv;
		logic need_sqrt;
		logic need_jdiv;
		logic is_last;
		logic iter_done;
		logic out_free;
	} vda_status_t;

endpackage

### rtl/core/vector_distance_accumulator.sv
// Top level of the vector distance accumulator.
// Depends on vda_pkg, vda_ctrl and vda_datapath.
//
// channel | handshake             | payload
// --------+-----------------------+-----------------------------------
// input   | in_valid / in_stall   | x_value, y_value, last_element
// output  | out_valid / out_stall | distance, saturated
// config  | cfg_valid / cfg_ready | cfg_data (metric)
//
// An element passes the capture, square/prepare and accumulate steps; canberra adds
// a pass through the shared one-bit-per-cycle divider.
// The last element adds the finish and emit steps plus the square root (euclidean)
// or the divider (jaccard with positive denominator).
// The result sits in an output register; new elements are taken while it waits,
// and a following result waits in the emit step until the register is free.
// Reset clears the metric to euclidean and all sums to zero.
module vector_distance_accumulator #(
	parameter int FRAC_BITS = vda_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [vda_pkg::DATA_W-1:0]  x_value,
	input  logic signed [vda_pkg::DATA_W-1:0]  y_value,
	input  logic                               last_element,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [vda_pkg::DATA_W-1:0]  distance,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vda_pkg::MET_W-1:0]          cfg_data
);

	vda_pkg::vda_cmd_t    cmd;
	vda_pkg::vda_status_t st;

	// config writes always land at once
	assign cfg_ready = 1'b1;

	vda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	vda_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.x_value      (x_value),
		.y_value      (y_value),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.saturated    (saturated)
	);

endmodule

### rtl/core/vda_ctrl.sv
// Controller state machine of the vector distance accumulator.
// Depends on vda_pkg; drives the datapath through vda_cmd_t.
module vda_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  vda_pkg::vda_status_t st,
	output vda_pkg::vda_cmd_t    cmd
);

	vda_pkg::vda_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vda_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = (state_q != vda_pkg::ST_IDLE);
		unique case (state_q)
			vda_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = vda_pkg::ST_PREP;
				end
			end
			vda_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				if (st.need_cdiv) begin
					cmd.cdiv_start = 1'b1;
					state_nxt      = vda_pkg::ST_CDIV;
				end else begin
					state_nxt = vda_pkg::ST_ACC;
				end
			end
			vda_pkg::ST_CDIV: begin
				if (st.iter_done) begin
					state_nxt = vda_pkg::ST_ACC;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			vda_pkg::ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_nxt = st.is_last ? vda_pkg::ST_FIN : vda_pkg::ST_IDLE;
			end
			vda_pkg::ST_FIN: begin
				if (st.need_sqrt) begin
					cmd.sqrt_start = 1'b1;
					state_nxt      = vda_pkg::ST_SQRT;
				end else if (st.need_jdiv) begin
					cmd.jdiv_start = 1'b1;
					state_nxt      = vda_pkg::ST_JDIV;
				end else begin
					state_nxt = vda_pkg::ST_EMIT;
				end
			end
			vda_pkg::ST_SQRT: begin
				if (st.iter_done) begin
					state_nxt = vda_pkg::ST_EMIT;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			vda_pkg::ST_JDIV: begin
				if (st.iter_done) begin
					state_nxt = vda_pkg::ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			vda_pkg::ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = vda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = vda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/vda_datapath.sv
// Datapath of the vector distance accumulator: sums, divider, square root, output.
// Depends on vda_pkg; commanded by vda_ctrl.
module vda_datapath #(
	parameter int FRAC_BITS = vda_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vda_pkg::vda_cmd_t                  cmd,
	output vda_pkg::vda_status_t               st,
	input  logic                               cfg_we,
	input  logic [vda_pkg::MET_W-1:0]          cfg_data,
	input  logic signed [vda_pkg::DATA_W-1:0]  x_value,
	input  logic signed [vda_pkg::DATA_W-1:0]  y_value,
	input  logic                               last_element,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [vda_pkg::DATA_W-1:0]  distance,
	output logic                               saturated
);

	localparam int DW = vda_pkg::DATA_W;
	localparam int SW = vda_pkg::SUM_W;
	localparam int NW = SW + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam int QW = DW - 1;

	logic [vda_pkg::MET_W-1:0] metric_q;
	logic signed [DW-1:0]      x_q, y_q;
	logic                      last_q;
	logic [SW-1:0]             prod_q;
	logic [SW-1:0]             main_q, den_q;
	logic                      ovf_q;
	logic [NW-1:0]             num_q;
	logic [SW:0]               rem_q, dvs_q;
	logic [QW-1:0]             quo_q;
	logic                      qovf_q;
	logic [CW-1:0]             cnt_q;
	logic [SW-1:0]             sv_q, sr_q, sbit_q;
	logic                      out_valid_q;
	logic [DW-1:0]             dist_q;
	logic                      sat_q;

	// element terms
	logic [DW:0]   diff;
	logic [DW-1:0] ad, ax, ay;
	logic [DW:0]   cden;
	logic signed [DW-1:0] mn, mx;

	always_comb begin
		diff = {x_q[DW-1], x_q} - {y_q[DW-1], y_q};
		ad   = diff[DW] ? DW'(-diff) : diff[DW-1:0];
		ax   = x_q[DW-1] ? -x_q : x_q;
		ay   = y_q[DW-1] ? -y_q : y_q;
		cden = {1'b0, ax} + {1'b0, ay};
		mn   = (x_q < y_q) ? x_q : y_q;
		mx   = (x_q < y_q) ? y_q : x_q;
	end

	// saturating sums
	logic [SW:0]   usum;
	logic [SW-1:0] uadd;
	logic [SW-1:0] mn64, mx64, smin, smax;
	logic          smin_ovf, smax_ovf;

	always_comb begin
		unique case (metric_q)
			vda_pkg::MET_EUCLID:    uadd = prod_q;
			vda_pkg::MET_MANHATTAN: uadd = {{(SW-DW){1'b0}}, ad};
			vda_pkg::MET_CANBERRA:  uadd = (cden == '0) ? '0 : {{(SW-QW){1'b0}}, quo_q};
			default:                uadd = '0;
		endcase
		usum     = {1'b0, main_q} + {1'b0, uadd};
		mn64     = {{(SW-DW){mn[DW-1]}}, mn};
		mx64     = {{(SW-DW){mx[DW-1]}}, mx};
		smin     = main_q + mn64;
		smax     = den_q + mx64;
		smin_ovf = (main_q[SW-1] == mn64[SW-1]) && (smin[SW-1] != main_q[SW-1]);
		smax_ovf = (den_q[SW-1] == mx64[SW-1]) && (smax[SW-1] != den_q[SW-1]);
	end

	// jaccard operands
	logic          den_pos;
	logic [SW-1:0] jmag;
	assign den_pos = !den_q[SW-1] && (den_q != '0);
	assign jmag    = main_q[SW-1] ? -main_q : main_q;

	// divider and square root step logic
	logic [SW:0]   rem_sh, rem_sub;
	logic          rem_ge;
	logic [SW-1:0] sq_t;
	assign rem_sh  = {rem_q[SW-1:0], num_q[NW-1]};
	assign rem_sub = rem_sh - dvs_q;
	assign rem_ge  = (rem_sh >= dvs_q);
	assign sq_t    = sr_q + sbit_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vda_pkg::MET_EUCLID;
		end else if (cfg_we) begin
			metric_q <= cfg_data;
		end
	end

	// capture item and square the difference
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= x_value;
			y_q    <= y_value;
			last_q <= last_element;
		end
		if (cmd.prep) begin
			prod_q <= SW'({{(SW-DW){1'b0}}, ad} * {{(SW-DW){1'b0}}, ad});
		end
	end

	// final result selection
	logic [DW-1:0] res;
	logic          res_sat;

	always_comb begin
		res     = '0;
		res_sat = ovf_q;
		unique case (metric_q)
			vda_pkg::MET_EUCLID: begin
				if (sr_q[SW-1:DW-1] != '0) begin
					res     = {1'b0, {(DW-1){1'b1}}};
					res_sat = 1'b1;
				end else begin
					res = sr_q[DW-1:0];
				end
			end
			vda_pkg::MET_MAXIMUM, vda_pkg::MET_MANHATTAN, vda_pkg::MET_CANBERRA: begin
				if (main_q[SW-1:DW-1] != '0) begin
					res     = {1'b0, {(DW-1){1'b1}}};
					res_sat = 1'b1;
				end else begin
					res = main_q[DW-1:0];
				end
			end
			vda_pkg::MET_JACCARD: begin
				if (!den_pos) begin
					res = DW'(64'd1 << FRAC_BITS);
				end else if (qovf_q) begin
					res     = main_q[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
					res_sat = 1'b1;
				end else begin
					res = main_q[SW-1] ? -{1'b0, quo_q} : {1'b0, quo_q};
				end
			end
			vda_pkg::MET_OVERLAP: begin
				if (main_q[SW-1:DW-1] != '0 && main_q[SW-1:DW-1] != '1) begin
					res     = main_q[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
					res_sat = 1'b1;
				end else begin
					res = main_q[DW-1:0];
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// running sums: accumulate, clear on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= '0;
			den_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.emit) begin
			main_q <= '0;
			den_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.accumulate) begin
			unique case (metric_q)
				vda_pkg::MET_EUCLID, vda_pkg::MET_MANHATTAN, vda_pkg::MET_CANBERRA: begin
					if (usum[SW]) begin
						main_q <= '1;
						ovf_q  <= 1'b1;
					end else begin
						main_q <= usum[SW-1:0];
					end
				end
				vda_pkg::MET_MAXIMUM: begin
					if ({{(SW-DW){1'b0}}, ad} > main_q) begin
						main_q <= {{(SW-DW){1'b0}}, ad};
					end
				end
				vda_pkg::MET_JACCARD, vda_pkg::MET_OVERLAP: begin
					if (smin_ovf) begin
						main_q <= mn64[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
						ovf_q  <= 1'b1;
					end else begin
						main_q <= smin;
					end
					if (metric_q == vda_pkg::MET_JACCARD) begin
						if (smax_ovf) begin
							den_q <= mx64[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
							ovf_q <= 1'b1;
						end else begin
							den_q <= smax;
						end
					end
				end
				default: begin
					main_q <= main_q;
				end
			endcase
		end
	end

	// iteration counter shared by divider and square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cdiv_start) begin
			cnt_q <= CW'(DW + FRAC_BITS);
		end else if (cmd.jdiv_start) begin
			cnt_q <= CW'(NW);
		end else if (cmd.sqrt_start) begin
			cnt_q <= CW'(SW / 2);
		end else if (cmd.div_step || cmd.sqrt_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.cdiv_start) begin
			num_q  <= {ad, {(NW-DW){1'b0}}};
			dvs_q  <= {{(SW-DW){1'b0}}, cden};
			rem_q  <= '0;
			quo_q  <= '0;
			qovf_q <= 1'b0;
		end else if (cmd.jdiv_start) begin
			num_q  <= {jmag, {FRAC_BITS{1'b0}}};
			dvs_q  <= {1'b0, den_q};
			rem_q  <= '0;
			quo_q  <= '0;
			qovf_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= rem_ge ? rem_sub : rem_sh;
			quo_q  <= {quo_q[QW-2:0], rem_ge};
			qovf_q <= qovf_q | quo_q[QW-1];
		end
	end

	// digit-by-digit square root, two radicand bits per cycle
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sv_q   <= main_q;
			sr_q   <= '0;
			sbit_q <= {2'b01, {(SW-2){1'b0}}};
		end else if (cmd.sqrt_step) begin
			if (sv_q >= sq_t) begin
				sv_q <= sv_q - sq_t;
				sr_q <= (sr_q >> 1) + sbit_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dist_q <= res;
			sat_q  <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign saturated = sat_q;

	// status to controller
	always_comb begin
		st.need_cdiv = (metric_q == vda_pkg::MET_CANBERRA) && (cden != '0);
		st.need_sqrt = (metric_q == vda_pkg::MET_EUCLID);
		st.need_jdiv = (metric_q == vda_pkg::MET_JACCARD) && den_pos;
		st.is_last   = last_q;
		st.iter_done = (cnt_q == '0);
		st.out_free  = !out_valid_q || !out_stall;
	end

endmodule

### rtl/core/vda_checker.sv
// Port-level checks of the vector distance accumulator, bound to the top level.
// Depends on vector_distance_accumulator_assert.svh and vda_pkg.
`include "vector_distance_accumulator_assert.svh"

module vda_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [vda_pkg::DATA_W-1:0] distance,
	input logic                              saturated
);

	// hold a stalled result
	`VDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`VDA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(distance) && $stable(saturated))
	// busy right after an input transfer
	`VDA_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
	// a new result only comes out of a busy cycle
	`VDA_ASSERT_SAME(a_out_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.distance  (distance),
	.saturated (saturated)
);
